/* sv/lcdf_pkg.sv */
// ============================================================================
// lcdf_pkg - shared types and constants of the LCD serial command framer
// Holds the request kinds, the queued job format and the character tables.
// ============================================================================
`default_nettype none

package lcdf_pkg;

    // Request kinds carried on the func input
    localparam logic [2:0] FUNC_CMD   = 3'd0;
    localparam logic [2:0] FUNC_DATA  = 3'd1;
    localparam logic [2:0] FUNC_TEXT  = 3'd2;
    localparam logic [2:0] FUNC_GFX   = 3'd3;
    localparam logic [2:0] FUNC_GLYPH = 3'd4;

    // Panel geometry defaults
    localparam int GFX_ROWS_DEF  = 64;
    localparam int HALF_ROWS_DEF = 32;

    // Frame bytes and controller command codes
    localparam logic [7:0] SYNC_CMD   = 8'hF8;
    localparam logic [7:0] SYNC_DATA  = 8'hFA;
    localparam logic [7:0] MODE_EXT   = 8'h34;
    localparam logic [7:0] MODE_BASIC = 8'h30;
    localparam logic [7:0] ADDR_BASE  = 8'h80;
    localparam logic [7:0] ADDR_LOWER = 8'h88;

    // Job queue between the front and back parts
    localparam int JOB_WRITES  = 6;
    localparam int WR_IDX_W    = $clog2(JOB_WRITES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One register write on the controller
    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
    } t_write;

    // One classified request: its writes and the index of the final one
    typedef struct packed {
        logic [WR_IDX_W-1:0]        last_idx;
        t_write [JOB_WRITES-1:0]    writes;
    } t_job;

    // Character code of a digit glyph; unused indices send a space
    function automatic logic [7:0] glyph_code(input logic [3:0] idx);
        logic [7:0] code;
        case (idx)
            4'd0:    code = 8'h30;
            4'd1:    code = 8'h31;
            4'd2:    code = 8'h32;
            4'd3:    code = 8'h33;
            4'd4:    code = 8'h34;
            4'd5:    code = 8'h35;
            4'd6:    code = 8'h36;
            4'd7:    code = 8'h37;
            4'd8:    code = 8'h38;
            4'd9:    code = 8'h39;
            4'd10:   code = 8'h20;
            4'd11:   code = 8'h3A;
            4'd12:   code = 8'h2E;
            4'd13:   code = 8'h2D;
            default: code = 8'h20;
        endcase
        return code;
    endfunction

    // DDRAM base address of a text line
    function automatic logic [7:0] line_base(input logic [2:0] row);
        logic [7:0] base;
        case (row)
            3'd2:    base = 8'h90;
            3'd3:    base = 8'h88;
            3'd4:    base = 8'h98;
            default: base = 8'h80;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

/* sv/lcd_serial_command_framer_core.sv */
// ============================================================================
// lcd_serial_command_framer_core - three-wire serial framer for a graphic LCD
// Frames host requests into sync and nibble bytes for the panel controller.
// ============================================================================
//
//  channel   direction  handshake          word
//  request   in         i_push / o_full    i_func .. i_digit
//  frame     out        o_empty / i_pop    o_serial_byte, o_last
//
//  A request is classified in the cycle it is pushed and queued as a job.
//  The frame sequencer loads each job, then emits one byte per cycle unless
//  the output stalls: three for a command, data, cursor or glyph request,
//  eighteen for a graphics word. Unknown kinds are accepted and give no bytes.
//  Reset is synchronous and empties the queue and the output register.
//  A stalled output holds its byte; the queue keeps taking requests until full.
//
`default_nettype none

module lcd_serial_command_framer_core #(
    parameter int GFX_ROWS  = lcdf_pkg::GFX_ROWS_DEF,
    parameter int HALF_ROWS = lcdf_pkg::HALF_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [2:0] i_func,
    input  wire logic [7:0] i_byte_value,
    input  wire logic [2:0] i_text_row,
    input  wire logic [3:0] i_text_col,
    input  wire logic [5:0] i_gfx_row,
    input  wire logic [2:0] i_gfx_col,
    input  wire logic [7:0] i_gfx_high,
    input  wire logic [7:0] i_gfx_low,
    input  wire logic [3:0] i_digit,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_serial_byte,
    output logic            o_last
);

    lcdf_pkg::t_job     front_job;
    logic               front_valid;
    lcdf_pkg::t_job     queue_job;
    logic               queue_empty;
    logic               queue_take;

    // Request classification
    lcdf_front #(
        .GFX_ROWS  (GFX_ROWS),
        .HALF_ROWS (HALF_ROWS)
    ) u_front (
        .i_func       (i_func),
        .i_byte_value (i_byte_value),
        .i_text_row   (i_text_row),
        .i_text_col   (i_text_col),
        .i_gfx_row    (i_gfx_row),
        .i_gfx_col    (i_gfx_col),
        .i_gfx_high   (i_gfx_high),
        .i_gfx_low    (i_gfx_low),
        .i_digit      (i_digit),
        .o_job        (front_job),
        .o_job_valid  (front_valid)
    );

    // Job queue
    lcdf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_push && front_valid),
        .i_wr_job (front_job),
        .i_rd     (queue_take),
        .o_rd_job (queue_job),
        .o_full   (o_full),
        .o_empty  (queue_empty)
    );

    // Frame sequencing
    lcdf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (queue_job),
        .i_job_empty   (queue_empty),
        .o_job_take    (queue_take),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_serial_byte (o_serial_byte),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* sv/lcdf_front.sv */
// ============================================================================
// lcdf_front - request classifier
// Turns one host request into a job of controller register writes.
// ============================================================================
`default_nettype none

module lcdf_front #(
    parameter int GFX_ROWS  = lcdf_pkg::GFX_ROWS_DEF,
    parameter int HALF_ROWS = lcdf_pkg::HALF_ROWS_DEF
) (
    input  wire logic [2:0]     i_func,
    input  wire logic [7:0]     i_byte_value,
    input  wire logic [2:0]     i_text_row,
    input  wire logic [3:0]     i_text_col,
    input  wire logic [5:0]     i_gfx_row,
    input  wire logic [2:0]     i_gfx_col,
    input  wire logic [7:0]     i_gfx_high,
    input  wire logic [7:0]     i_gfx_low,
    input  wire logic [3:0]     i_digit,
    output lcdf_pkg::t_job      o_job,
    output logic                o_job_valid
);

    localparam logic [6:0] GFX_ROWS_C  = 7'(GFX_ROWS);
    localparam logic [6:0] HALF_ROWS_C = 7'(HALF_ROWS);
    localparam int         HALF_STEPS  = (64 + HALF_ROWS - 1) / HALF_ROWS;

    logic [6:0] row_wrapped;
    logic [6:0] row_in_half;
    logic       row_lower;
    logic [7:0] row_addr;
    logic [7:0] col_addr;

    // Row folding: the panel row first, then the row within its half
    always_comb begin
        if ({1'b0, i_gfx_row} >= GFX_ROWS_C) begin
            row_wrapped = {1'b0, i_gfx_row} - GFX_ROWS_C;
        end else begin
            row_wrapped = {1'b0, i_gfx_row};
        end
        row_lower   = row_wrapped >= HALF_ROWS_C;
        row_in_half = row_wrapped;
        for (int k = 0; k < HALF_STEPS; k++) begin
            if (row_in_half >= HALF_ROWS_C) begin
                row_in_half = row_in_half - HALF_ROWS_C;
            end
        end
        row_addr = lcdf_pkg::ADDR_BASE + {1'b0, row_in_half};
        col_addr = (row_lower ? lcdf_pkg::ADDR_LOWER : lcdf_pkg::ADDR_BASE)
                   + {5'd0, i_gfx_col};
    end

    // Job assembly by request kind
    always_comb begin
        o_job       = '0;
        o_job_valid = 1'b1;
        case (i_func)
            lcdf_pkg::FUNC_CMD: begin
                o_job.writes[0] = '{is_data: 1'b0, value: i_byte_value};
            end
            lcdf_pkg::FUNC_DATA: begin
                o_job.writes[0] = '{is_data: 1'b1, value: i_byte_value};
            end
            lcdf_pkg::FUNC_TEXT: begin
                o_job.writes[0] = '{is_data: 1'b0,
                    value: lcdf_pkg::line_base(i_text_row) + {4'd0, i_text_col}};
            end
            lcdf_pkg::FUNC_GFX: begin
                o_job.writes[0] = '{is_data: 1'b0, value: lcdf_pkg::MODE_EXT};
                o_job.writes[1] = '{is_data: 1'b0, value: row_addr};
                o_job.writes[2] = '{is_data: 1'b0, value: col_addr};
                o_job.writes[3] = '{is_data: 1'b0, value: lcdf_pkg::MODE_BASIC};
                o_job.writes[4] = '{is_data: 1'b1, value: i_gfx_high};
                o_job.writes[5] = '{is_data: 1'b1, value: i_gfx_low};
                o_job.last_idx  = lcdf_pkg::WR_IDX_W'(lcdf_pkg::JOB_WRITES - 1);
            end
            lcdf_pkg::FUNC_GLYPH: begin
                o_job.writes[0] = '{is_data: 1'b1, value: lcdf_pkg::glyph_code(i_digit)};
            end
            default: begin
                o_job_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/lcdf_queue.sv */
// ============================================================================
// lcdf_queue - job queue
// A short first-in first-out store of classified jobs between the two parts.
// ============================================================================
`default_nettype none

module lcdf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire lcdf_pkg::t_job i_wr_job,
    input  wire logic           i_rd,
    output lcdf_pkg::t_job      o_rd_job,
    output logic                o_full,
    output logic                o_empty
);

    lcdf_pkg::t_job                   r_mem [lcdf_pkg::QUEUE_DEPTH];
    logic [lcdf_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [lcdf_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [lcdf_pkg::QUEUE_CW-1:0]    r_count;
    logic                             do_wr;
    logic                             do_rd;

    assign o_full   = r_count == lcdf_pkg::QUEUE_CW'(lcdf_pkg::QUEUE_DEPTH);
    assign o_empty  = r_count == '0;
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;
    assign o_rd_job = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == lcdf_pkg::QUEUE_AW'(lcdf_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == lcdf_pkg::QUEUE_AW'(lcdf_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/lcdf_back.sv */
// ============================================================================
// lcdf_back - frame sequencer
// Takes jobs from the queue and emits three frame bytes for each write.
// ============================================================================
`default_nettype none

module lcdf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lcdf_pkg::t_job i_job,
    input  wire logic           i_job_empty,
    output logic                o_job_take,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [7:0]          o_serial_byte,
    output logic                o_last
);

    // Position within the three-byte frame of one write
    typedef enum logic [1:0] {
        BYTE_SYNC,
        BYTE_HIGH,
        BYTE_LOW
    } t_byte_pos;

    lcdf_pkg::t_job                   r_job;
    logic                             r_busy;
    logic [lcdf_pkg::WR_IDX_W-1:0]    r_wr_idx;
    t_byte_pos                        r_byte_idx;
    logic                             r_out_valid;
    logic [7:0]                       r_out_byte;
    logic                             r_out_last;

    lcdf_pkg::t_write                 cur_wr;
    logic [7:0]                       frame_byte;
    logic                             pop_ok;
    logic                             step;
    logic                             end_write;
    logic                             end_job;

    assign o_empty       = !r_out_valid;
    assign o_serial_byte = r_out_byte;
    assign o_last        = r_out_last;
    assign o_job_take    = !r_busy && !i_job_empty;

    // Current byte of the frame being sent
    always_comb begin
        cur_wr    = r_job.writes[r_wr_idx];
        pop_ok    = i_pop && r_out_valid;
        step      = r_busy && (!r_out_valid || pop_ok);
        end_write = r_byte_idx == BYTE_LOW;
        end_job   = end_write && (r_wr_idx == r_job.last_idx);
        case (r_byte_idx)
            BYTE_SYNC: frame_byte = cur_wr.is_data ? lcdf_pkg::SYNC_DATA
                                                   : lcdf_pkg::SYNC_CMD;
            BYTE_HIGH: frame_byte = {cur_wr.value[7:4], 4'b0000};
            BYTE_LOW:  frame_byte = {cur_wr.value[3:0], 4'b0000};
            default:   frame_byte = '0;
        endcase
    end

    // Job register
    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_wr_idx    <= '0;
            r_byte_idx  <= BYTE_SYNC;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            if (o_job_take) begin
                r_busy     <= 1'b1;
                r_wr_idx   <= '0;
                r_byte_idx <= BYTE_SYNC;
            end else if (step) begin
                if (end_job) begin
                    r_busy <= 1'b0;
                end
                if (end_write) begin
                    r_byte_idx <= BYTE_SYNC;
                    r_wr_idx   <= r_wr_idx + 1'b1;
                end else begin
                    r_byte_idx <= (r_byte_idx == BYTE_SYNC) ? BYTE_HIGH : BYTE_LOW;
                end
            end
            if (step) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= frame_byte;
                r_out_last  <= end_job;
            end else if (pop_ok) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* test/tb_lcd_serial_command_framer_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_lcd_serial_command_framer_core - self-checking bench for the LCD framer
// Sends directed and random requests, predicts the sync and nibble bytes of
// each one, and compares every popped frame byte with the oldest prediction
// while both sides of the block stall at random.
// ============================================================================

module tb_lcd_serial_command_framer_core;

    // Codes that this bench does not find in the package
    localparam logic [2:0] FUNC_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] FUNC_UNKNOWN_HI = 3'd7;
    localparam logic [7:0] LINE1_BASE      = 8'h80;
    localparam logic [7:0] LINE2_BASE      = 8'h90;
    localparam logic [7:0] LINE3_BASE      = 8'h88;
    localparam logic [7:0] LINE4_BASE      = 8'h98;
    localparam logic [7:0] NIBBLE_MASK     = 8'hF0;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int DRAIN_CYCLES       = 16;
    localparam int READER_HOLD_CYCLES = 300;
    localparam int GAP_PERCENT        = 8;
    localparam int POP_GAP_PERCENT    = 4;

    // One host request word, every field at its port width
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] byte_value;
        logic [2:0] text_row;
        logic [3:0] text_col;
        logic [5:0] gfx_row;
        logic [2:0] gfx_col;
        logic [7:0] gfx_high;
        logic [7:0] gfx_low;
        logic [3:0] digit;
    } t_lcd_request;

    // One frame byte as it should leave the block
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [2:0] i_func = '0;
    logic [7:0] i_byte_value = '0;
    logic [2:0] i_text_row = '0;
    logic [3:0] i_text_col = '0;
    logic [5:0] i_gfx_row = '0;
    logic [2:0] i_gfx_col = '0;
    logic [7:0] i_gfx_high = '0;
    logic [7:0] i_gfx_low = '0;
    logic [3:0] i_digit = '0;
    logic       i_pop = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [7:0] o_serial_byte;
    logic       o_last;

    t_frame_byte pending_frame_bytes[$];
    int          error_count = 0;
    int          bytes_checked = 0;
    int          requests_by_kind[8];
    int          full_stall_cycles = 0;
    int          cycle_count = 0;
    logic        no_gaps = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;
    int          pop_gap_left = 0;

    lcd_serial_command_framer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_func        (i_func),
        .i_byte_value  (i_byte_value),
        .i_text_row    (i_text_row),
        .i_text_col    (i_text_col),
        .i_gfx_row     (i_gfx_row),
        .i_gfx_col     (i_gfx_col),
        .i_gfx_high    (i_gfx_high),
        .i_gfx_low     (i_gfx_low),
        .i_digit       (i_digit),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_serial_byte (o_serial_byte),
        .o_last        (o_last)
    );

    // Clock of 4 ns period.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Character code of a digit glyph; indices past the minus sign give a space.
    function automatic logic [7:0] glyph_char(input logic [3:0] idx);
        logic [7:0] code;
        if (idx < 4'd10) begin
            code = 8'h30 + {4'd0, idx};
        end else begin
            case (idx)
                4'd11:   code = ":";
                4'd12:   code = ".";
                4'd13:   code = "-";
                default: code = " ";
            endcase
        end
        return code;
    endfunction

    // One controller register write becomes a sync byte and two nibble bytes.
    function automatic void expect_register_write(input logic is_data,
                                                  input logic [7:0] value);
        t_frame_byte fb;
        fb.last  = 1'b0;
        fb.value = is_data ? lcdf_pkg::SYNC_DATA : lcdf_pkg::SYNC_CMD;
        pending_frame_bytes.push_back(fb);
        fb.value = value & NIBBLE_MASK;
        pending_frame_bytes.push_back(fb);
        fb.value = (value << 4) & NIBBLE_MASK;
        pending_frame_bytes.push_back(fb);
    endfunction

    // Predicts the frame bytes that one accepted request produces.
    function automatic void frame_request(input t_lcd_request req);
        int         first_idx;
        logic [7:0] base;
        int         row;
        logic       lower_half;
        first_idx = pending_frame_bytes.size();
        case (req.func)
            lcdf_pkg::FUNC_CMD:  expect_register_write(1'b0, req.byte_value);
            lcdf_pkg::FUNC_DATA: expect_register_write(1'b1, req.byte_value);
            lcdf_pkg::FUNC_TEXT: begin
                case (req.text_row)
                    3'd2:    base = LINE2_BASE;
                    3'd3:    base = LINE3_BASE;
                    3'd4:    base = LINE4_BASE;
                    default: base = LINE1_BASE;
                endcase
                expect_register_write(1'b0, base + {4'd0, req.text_col});
            end
            lcdf_pkg::FUNC_GFX: begin
                row        = int'(req.gfx_row) % lcdf_pkg::GFX_ROWS_DEF;
                lower_half = (row >= lcdf_pkg::HALF_ROWS_DEF);
                expect_register_write(1'b0, lcdf_pkg::MODE_EXT);
                expect_register_write(1'b0,
                    lcdf_pkg::ADDR_BASE + 8'(row % lcdf_pkg::HALF_ROWS_DEF));
                expect_register_write(1'b0,
                    (lower_half ? lcdf_pkg::ADDR_LOWER : lcdf_pkg::ADDR_BASE)
                    + {5'd0, req.gfx_col});
                expect_register_write(1'b0, lcdf_pkg::MODE_BASIC);
                expect_register_write(1'b1, req.gfx_high);
                expect_register_write(1'b1, req.gfx_low);
            end
            lcdf_pkg::FUNC_GLYPH: expect_register_write(1'b1, glyph_char(req.digit));
            default: ;
        endcase
        // The final byte of a request carries the last flag.
        if (pending_frame_bytes.size() > first_idx) begin
            pending_frame_bytes[pending_frame_bytes.size() - 1].last = 1'b1;
        end
    endfunction

    // A request word with every field random and the given kind.
    function automatic t_lcd_request random_request(input logic [2:0] func);
        t_lcd_request req;
        logic [63:0]  raw;
        raw            = {$urandom, $urandom};
        req            = t_lcd_request'(raw[$bits(t_lcd_request)-1:0]);
        req.func       = func;
        return req;
    endfunction

    // Random kind: mostly real requests, now and then an unknown one.
    function automatic logic [2:0] random_func();
        logic [2:0] func;
        if ($urandom_range(99) < 6) begin
            func = 3'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI));
        end else begin
            func = 3'($urandom_range(lcdf_pkg::FUNC_CMD, lcdf_pkg::FUNC_GLYPH));
        end
        return func;
    endfunction

    // Offers one request word, waits until it is taken, then maybe pauses.
    task automatic send_request(input t_lcd_request req);
        i_push       <= 1'b1;
        i_func       <= req.func;
        i_byte_value <= req.byte_value;
        i_text_row   <= req.text_row;
        i_text_col   <= req.text_col;
        i_gfx_row    <= req.gfx_row;
        i_gfx_col    <= req.gfx_col;
        i_gfx_high   <= req.gfx_high;
        i_gfx_low    <= req.gfx_low;
        i_digit      <= req.digit;
        @(posedge i_clk);
        while (o_full) begin
            @(posedge i_clk);
        end
        frame_request(req);
        requests_by_kind[req.func]++;
        if (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Sends random requests until the given number of real ones has gone.
    task automatic send_random_requests(input int count);
        t_lcd_request req;
        int           sent;
        sent = 0;
        while (sent < count) begin
            req = random_request(random_func());
            send_request(req);
            if (req.func <= lcdf_pkg::FUNC_GLYPH) begin
                sent++;
            end
        end
    endtask

    // Raw command and data writes at the byte extremes.
    task automatic test_raw_writes();
        t_lcd_request req;
        req = random_request(lcdf_pkg::FUNC_CMD);
        req.byte_value = 8'h00;
        send_request(req);
        req.byte_value = 8'hFF;
        send_request(req);
        req = random_request(lcdf_pkg::FUNC_DATA);
        req.byte_value = 8'h00;
        send_request(req);
        req.byte_value = 8'hFF;
        send_request(req);
    endtask

    // Every text line selector, columns at both ends.
    task automatic test_text_cursor();
        t_lcd_request req;
        for (int row = 0; row < 8; row++) begin
            req = random_request(lcdf_pkg::FUNC_TEXT);
            req.text_row = 3'(row);
            req.text_col = row[0] ? 4'd15 : 4'd0;
            send_request(req);
        end
    endtask

    // Graphics words on both sides of the half-panel boundary.
    task automatic test_graphics_word();
        t_lcd_request req;
        logic [5:0]   rows[4];
        rows = '{6'd0, 6'd31, 6'd32, 6'd63};
        for (int i = 0; i < 4; i++) begin
            req = random_request(lcdf_pkg::FUNC_GFX);
            req.gfx_row  = rows[i];
            req.gfx_col  = i[0] ? 3'd7 : 3'd0;
            req.gfx_high = i[0] ? 8'hFF : 8'h00;
            req.gfx_low  = i[0] ? 8'h00 : 8'hFF;
            send_request(req);
        end
    endtask

    // Glyph indices at the table edges and past its end.
    task automatic test_digit_glyph();
        t_lcd_request req;
        logic [3:0]   digits[6];
        digits = '{4'd0, 4'd9, 4'd10, 4'd13, 4'd14, 4'd15};
        for (int i = 0; i < 6; i++) begin
            req = random_request(lcdf_pkg::FUNC_GLYPH);
            req.digit = digits[i];
            send_request(req);
        end
    endtask

    // Unknown kinds are taken and produce no bytes.
    task automatic test_unknown_kind();
        for (int f = FUNC_UNKNOWN_LO; f <= FUNC_UNKNOWN_HI; f++) begin
            send_request(random_request(3'(f)));
        end
    endtask

    // Random traffic with random gaps on both sides.
    task automatic test_random_traffic();
        send_random_requests(200);
    endtask

    // A stretch with neither side idling.
    task automatic test_back_to_back();
        no_gaps <= 1'b1;
        send_random_requests(60);
        no_gaps <= 1'b0;
    endtask

    // The reader holds off while requests keep coming, so the block fills up.
    task automatic test_full_backpressure();
        hold_req <= ~hold_req;
        send_random_requests(40);
    endtask

    // Waits until every predicted byte has been popped, then a little longer.
    task automatic wait_drained();
        while (pending_frame_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Pop side: random gaps, a long hold-off on request, none in the quiet stretch.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= READER_HOLD_CYCLES;
            i_pop     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_pop     <= 1'b0;
        end else if (no_gaps) begin
            i_pop <= 1'b1;
        end else if (pop_gap_left != 0) begin
            pop_gap_left <= pop_gap_left - 1;
            i_pop        <= 1'b0;
        end else if ($urandom_range(99) < POP_GAP_PERCENT) begin
            pop_gap_left <= $urandom_range(0, 2);
            i_pop        <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    // Each popped word is compared with the oldest predicted byte.
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_push && o_full) begin
            full_stall_cycles++;
        end
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_frame_bytes.size() == 0) begin
                $display("%0t: unexpected frame byte: expected none, actual %02h last %0b",
                         $time, o_serial_byte, o_last);
                error_count++;
            end else begin
                want = pending_frame_bytes.pop_front();
                bytes_checked++;
                if (o_serial_byte !== want.value) begin
                    $display("%0t: serial_byte mismatch: expected %02h, actual %02h",
                             $time, want.value, o_serial_byte);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Cycle counter that ends a run that hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d frame bytes still expected",
                 $time, pending_frame_bytes.size());
        $display("tb_lcd_serial_command_framer_core: done, errors");
        $finish;
    end

    // Test sequence.
    initial begin
        foreach (requests_by_kind[k]) requests_by_kind[k] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_raw_writes();
        test_text_cursor();
        test_graphics_word();
        test_digit_glyph();
        test_unknown_kind();
        test_random_traffic();
        test_back_to_back();
        test_full_backpressure();

        i_push <= 1'b0;
        wait_drained();

        $display("Requests: %0d command, %0d data, %0d cursor, %0d graphics, %0d glyph",
                 requests_by_kind[lcdf_pkg::FUNC_CMD], requests_by_kind[lcdf_pkg::FUNC_DATA],
                 requests_by_kind[lcdf_pkg::FUNC_TEXT], requests_by_kind[lcdf_pkg::FUNC_GFX],
                 requests_by_kind[lcdf_pkg::FUNC_GLYPH]);
        $display("Ignored kinds: %0d; frame bytes checked: %0d; cycles stalled on full: %0d",
                 requests_by_kind[FUNC_UNKNOWN_LO]
                 + requests_by_kind[FUNC_UNKNOWN_LO + 3'd1]
                 + requests_by_kind[FUNC_UNKNOWN_HI],
                 bytes_checked, full_stall_cycles);
        if (error_count == 0 && pending_frame_bytes.size() == 0) begin
            $display("tb_lcd_serial_command_framer_core: done, clean");
        end else begin
            $display("tb_lcd_serial_command_framer_core: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
sv/lcdf_pkg.sv
sv/lcdf_front.sv
sv/lcdf_queue.sv
sv/lcdf_back.sv
sv/lcd_serial_command_framer_core.sv
test/tb_lcd_serial_command_framer_core.sv
